### design/wcms_pkg.sv
// Shared types, constants and the xorshift helper for the windowed count-min sketch.
package wcms_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxRows    = 4;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxRows);
  localparam int unsigned CellAddrW  = 1 + RowW + ColW;
  localparam int unsigned TableCells = 2 * MaxRows * MaxWidth;

  localparam logic [31:0] FnvBasis = 32'h811c9dc5;
  localparam logic [31:0] FnvPrime = 32'h01000193;
  localparam logic [31:0] MixMul   = 32'h7feb352d;
  localparam logic [31:0] CountMax = 32'hffffffff;

  typedef enum logic [1:0] {
    KindInc    = 2'd0,
    KindQuery  = 2'd1,
    KindRotate = 2'd2,
    KindSeed   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RegWidthLog2 = 3'd0,
    RegRows      = 3'd1,
    RegCons      = 3'd2,
    RegMix       = 3'd3,
    RegSeedRot   = 3'd4,
    RegGenStart  = 3'd5
  } reg_e;

  // xorshift32 step
  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

### design/windowed_count_min_sketch_top.sv
// Top level of the windowed count-min sketch: sequencer, hash unit and counter memory.
//
//  channel | direction | signals                          | request moves
//  in      | input     | in_valid_i/in_ready_o kind,ident | one command
//  out     | output    | out_valid_o/out_ready_i estimate | one query result
//  cfg     | input     | APB psel..pready                 | one register write
//
// Each row hash runs one byte per cycle through one shared 32x32 multiplier,
// plus one mix step with hash_mix. Increment, per row: hash, read, wait,
// update, next; conservative walks rows twice.
// Query: hash twice per row. Rotate: one cycle per cleared cell (rows*width), up to 4096 cells.
// Reset: a clearing pass sweeps all 8192 cells of the counter memory; no
// command is taken meanwhile. A waiting result holds off the next command.
module windowed_count_min_sketch_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] identity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [32:0] estimate_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [10:0] {
    StClear  = 11'b00000000001,
    StIdle   = 11'b00000000010,
    StHash   = 11'b00000000100,
    StMix    = 11'b00000001000,
    StRead   = 11'b00000010000,
    StWait   = 11'b00000100000,
    StUse    = 11'b00001000000,
    StRotClr = 11'b00010000000,
    StSeed   = 11'b00100000000,
    StOut    = 11'b01000000000,
    StNext   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [3:0]  wlog_q;
  logic [2:0]  rows_q;
  logic        cons_q, mix_q, srot_q;
  logic [31:0] gen_q, rnd_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      wcms_pkg::RegWidthLog2: prdata = {28'd0, wlog_q};
      wcms_pkg::RegRows:      prdata = {29'd0, rows_q};
      wcms_pkg::RegCons:      prdata = {31'd0, cons_q};
      wcms_pkg::RegMix:       prdata = {31'd0, mix_q};
      wcms_pkg::RegSeedRot:   prdata = {31'd0, srot_q};
      wcms_pkg::RegGenStart:  prdata = gen_q;
      default:                prdata = 32'd0;
    endcase
  end

  // effective geometry
  logic [2:0] nrows;
  logic [wcms_pkg::ColW:0] width;
  assign nrows = (rows_q > 3'(wcms_pkg::MaxRows)) ? 3'(wcms_pkg::MaxRows) : rows_q;
  assign width = (wlog_q >= 4'(wcms_pkg::ColW)) ? (wcms_pkg::ColW+1)'(wcms_pkg::MaxWidth)
               : (wcms_pkg::ColW+1)'(1) << wlog_q;

  // seeds
  logic [31:0] seed_q [2*wcms_pkg::MaxRows];

  // counter memory
  logic [31:0] mem [wcms_pkg::TableCells];
  logic [wcms_pkg::CellAddrW-1:0] maddr;
  logic        mwe;
  logic [31:0] mwdata, mrdata_q;
  always_ff @(posedge clk_i) begin
    if (mwe) mem[maddr] <= mwdata;
    mrdata_q <= mem[maddr];
  end

  // working registers
  logic [1:0]  kind_q;
  logic [63:0] ident_q;
  logic        buf_q;          // current buffer
  logic        sel_q;          // buffer under work
  logic [2:0]  row_q;
  logic        pass_q;         // conservative: 0 find min, 1 raise
  logic [3:0]  step_q;
  logic [31:0] h_q, h_d;
  logic [wcms_pkg::ColW-1:0] col_q;
  logic [31:0] low_q, cur_q;
  logic [32:0] best_q;
  logic [wcms_pkg::ColW:0] clr_q;
  logic [wcms_pkg::CellAddrW:0] sweep_q;
  logic [63:0] rotcnt_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b, mul_p;
  assign mul_p = mul_a * mul_b;
  logic [31:0] hx;
  always_comb begin
    mul_b = wcms_pkg::FnvPrime;
    hx    = h_q ^ {24'd0, ident_q[8*step_q[2:0] +: 8]};
    mul_a = hx;
    if (state_q == StMix) begin
      mul_b = wcms_pkg::MixMul;
      mul_a = h_q;
    end
  end

  logic [wcms_pkg::ColW-1:0] col_of;
  assign col_of = h_d[wcms_pkg::ColW-1:0] & (width[wcms_pkg::ColW-1:0] - 1'b1);

  logic [31:0] nxt_rnd, nxt_rnd2;
  assign nxt_rnd  = wcms_pkg::xorshift(rnd_q);
  assign nxt_rnd2 = wcms_pkg::xorshift(nxt_rnd);

  logic last_row;
  assign last_row = (row_q + 3'd1 >= nrows);

  // conservative increment goes on to the raise pass
  logic cons_again;
  assign cons_again = (kind_q == wcms_pkg::KindInc) && cons_q && !pass_q
                      && (low_q != wcms_pkg::CountMax);

  logic query_prev;
  assign query_prev = (kind_q == wcms_pkg::KindQuery) && (sel_q == buf_q);

  always_comb begin
    maddr = {sel_q, row_q[wcms_pkg::RowW-1:0], col_q};
    mwe = 1'b0;
    mwdata = 32'd0;
    h_d = h_q;
    case (state_q)
      StClear: begin
        maddr = sweep_q[wcms_pkg::CellAddrW-1:0];
        mwe = 1'b1;
      end
      StIdle: begin
        if (in_valid_i)
          h_d = wcms_pkg::FnvBasis ^ seed_q[{buf_q, {wcms_pkg::RowW{1'b0}}}];
      end
      // first avalanche shift is folded in after the last byte
      StHash:  h_d = (step_q == 4'd7 && mix_q) ? (mul_p ^ (mul_p >> 16)) : mul_p;
      StMix:   h_d = mul_p ^ (mul_p >> 15);
      StRotClr: begin
        maddr = {sel_q, row_q[wcms_pkg::RowW-1:0], clr_q[wcms_pkg::ColW-1:0]};
        mwe = 1'b1;
      end
      StUse: begin
        if (kind_q == wcms_pkg::KindInc) begin
          if (!cons_q) begin
            mwe = 1'b1; mwdata = mrdata_q + 32'd1;
          end else if (pass_q && mrdata_q < low_q + 32'd1) begin
            mwe = 1'b1; mwdata = low_q + 32'd1;
          end
        end
      end
      StNext: begin
        if (query_prev)
          h_d = wcms_pkg::FnvBasis ^ seed_q[{~buf_q, row_q[wcms_pkg::RowW-1:0]}];
        else if (!last_row)
          h_d = wcms_pkg::FnvBasis ^ seed_q[{buf_q, row_q[wcms_pkg::RowW-1:0] + 1'b1}];
        else if (cons_again)
          h_d = wcms_pkg::FnvBasis ^ seed_q[{buf_q, {wcms_pkg::RowW{1'b0}}}];
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign estimate_o  = best_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (sweep_q == (wcms_pkg::CellAddrW+1)'(wcms_pkg::TableCells - 1))
                 state_d = StIdle;
      StIdle: if (in_valid_i) begin
        case (kind_i)
          wcms_pkg::KindRotate: state_d = (nrows == 3'd0) ? StIdle : StRotClr;
          wcms_pkg::KindSeed:   state_d = (nrows == 3'd0) ? StIdle : StSeed;
          wcms_pkg::KindQuery:  state_d = (nrows == 3'd0) ? StOut : StHash;
          default:              state_d = (nrows == 3'd0) ? StIdle : StHash;
        endcase
      end
      StHash:  if (step_q == 4'd7) state_d = mix_q ? StMix : StRead;
      StMix:   state_d = StRead;
      StRead:  state_d = StWait;
      StWait:  state_d = StUse;
      StUse:   state_d = StNext;
      StNext: begin
        if (query_prev || !last_row || cons_again) state_d = StHash;
        else state_d = (kind_q == wcms_pkg::KindQuery) ? StOut : StIdle;
      end
      StRotClr: if (clr_q + 1'b1 == width && last_row) state_d = StIdle;
      StSeed:  if (last_row) state_d = StIdle;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      wlog_q <= 4'd10; rows_q <= 3'd4; cons_q <= 1'b0; mix_q <= 1'b0;
      srot_q <= 1'b0; gen_q <= 32'd1; rnd_q <= 32'd1;
      buf_q <= 1'b0; rotcnt_q <= 64'd0; sweep_q <= '0;
      for (int i = 0; i < 2*wcms_pkg::MaxRows; i++) seed_q[i] <= 32'd0;
      kind_q <= wcms_pkg::KindInc; ident_q <= 64'd0; sel_q <= 1'b0; row_q <= 3'd0;
      pass_q <= 1'b0; step_q <= 4'd0; h_q <= 32'd0; col_q <= '0; low_q <= 32'd0;
      cur_q <= 32'd0; best_q <= 33'd0; clr_q <= '0;
    end else begin
      state_q <= state_d;
      h_q <= h_d;
      if (cfg_wr) begin
        case (paddr[4:2])
          wcms_pkg::RegWidthLog2: wlog_q <= pwdata[3:0];
          wcms_pkg::RegRows:      rows_q <= pwdata[2:0];
          wcms_pkg::RegCons:      cons_q <= pwdata[0];
          wcms_pkg::RegMix:       mix_q  <= pwdata[0];
          wcms_pkg::RegSeedRot:   srot_q <= pwdata[0];
          wcms_pkg::RegGenStart: begin
            gen_q <= pwdata;
            rnd_q <= (pwdata == 32'd0) ? 32'd1 : pwdata;
          end
          default: ;
        endcase
      end
      case (state_q)
        StClear: sweep_q <= sweep_q + 1'b1;
        StIdle: if (in_valid_i) begin
          kind_q <= kind_i; ident_q <= identity_i; row_q <= 3'd0;
          pass_q <= 1'b0; step_q <= 4'd0; clr_q <= '0;
          low_q <= wcms_pkg::CountMax; best_q <= 33'd0;
          sel_q <= (kind_i == wcms_pkg::KindRotate) ? ~buf_q : buf_q;
          // with no rows in use a rotation still swaps buffers
          if (kind_i == wcms_pkg::KindRotate && nrows == 3'd0) begin
            buf_q <= ~buf_q; rotcnt_q <= rotcnt_q + 64'd1;
          end
        end
        StHash: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd7 && !mix_q) col_q <= col_of;
        end
        StMix: col_q <= col_of;
        StUse: begin
          cur_q <= mrdata_q;
          if (kind_q == wcms_pkg::KindInc && cons_q && !pass_q && mrdata_q < low_q)
            low_q <= mrdata_q;
          if (kind_q == wcms_pkg::KindQuery && sel_q != buf_q) begin
            if (row_q == 3'd0 || {1'b0, cur_q} + {1'b0, mrdata_q} < best_q)
              best_q <= {1'b0, cur_q} + {1'b0, mrdata_q};
          end
        end
        StNext: begin
          step_q <= 4'd0;
          if (query_prev) begin
            sel_q <= ~buf_q;
          end else if (!last_row) begin
            row_q <= row_q + 3'd1;
            sel_q <= buf_q;
          end else if (cons_again) begin
            pass_q <= 1'b1; row_q <= 3'd0;
          end
        end
        StRotClr: begin
          if (clr_q + 1'b1 == width) begin
            clr_q <= '0;
            if (srot_q) begin
              seed_q[{sel_q, row_q[wcms_pkg::RowW-1:0]}] <= nxt_rnd | 32'd1;
              rnd_q <= nxt_rnd;
            end
            if (last_row) begin
              buf_q <= sel_q; rotcnt_q <= rotcnt_q + 64'd1;
            end else row_q <= row_q + 3'd1;
          end else clr_q <= clr_q + 1'b1;
        end
        StSeed: begin
          seed_q[{1'b0, row_q[wcms_pkg::RowW-1:0]}] <= nxt_rnd | 32'd1;
          seed_q[{1'b1, row_q[wcms_pkg::RowW-1:0]}] <= nxt_rnd2 | 32'd1;
          rnd_q <= nxt_rnd2;
          row_q <= row_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(estimate_o))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result waits");
  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUse |-> row_q < 3'(wcms_pkg::MaxRows)) else $error("row overrun");

endmodule
